>>> design/gtsig_pkg.sv
// shared types and constants for the grid triangle strip index generator
`default_nettype none
package gtsig_pkg;

	// grid limits and field widths
	localparam int unsigned MAX_GRID_DIM = 1024;
	localparam int unsigned DIM_W        = 11;
	localparam int unsigned STEP_W       = 10;
	// strip start row: a step raised before a trailing repeat can push it past the grid
	localparam int unsigned ROW_W        = 11;
	localparam int unsigned VI_W         = 20;
	localparam int unsigned POS_W        = 22;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 11;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd2;

	// reset values of the configuration registers
	localparam logic [DIM_W-1:0]  ROW_LENGTH_RST = 11'd64;
	localparam logic [DIM_W-1:0]  ROW_COUNT_RST  = 11'd64;
	localparam logic [STEP_W-1:0] STEP_RST       = 10'd1;

	// strip walk phase
	typedef enum logic [3:0] {
		PH_TOP    = 4'b0001,
		PH_BOTTOM = 4'b0010,
		PH_LEAD   = 4'b0100,
		PH_TRAIL  = 4'b1000
	} phase_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [DIM_W-1:0]  row_length;
		logic [DIM_W-1:0]  row_count;
		logic [STEP_W-1:0] step;
	} cfg_t;

	// walker result handed to the index stage
	typedef struct packed {
		logic              valid_res;
		logic [ROW_W:0]    row;
		logic [DIM_W-1:0]  col;
		logic [POS_W-1:0]  position;
		logic              is_last;
	} walk_t;

endpackage
`default_nettype wire

>>> design/gtsig_if.sv
// request and result channel interfaces
`default_nettype none
interface gtsig_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface gtsig_res_if;
	logic                         valid;
	logic                         ready;
	logic                         valid_res;
	logic [gtsig_pkg::VI_W-1:0]   vertex_index;
	logic [gtsig_pkg::POS_W-1:0]  position;
	logic                         is_last;

	modport source (output valid, output valid_res, output vertex_index, output position,
		output is_last, input ready);
	modport sink (input valid, input valid_res, input vertex_index, input position,
		input is_last, output ready);
endinterface
`default_nettype wire

>>> design/gtsig_cfg.sv
// configuration registers with range clamping
`default_nettype none
module gtsig_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [gtsig_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gtsig_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output gtsig_pkg::cfg_t                       cfg
);

	logic [gtsig_pkg::DIM_W-1:0]  row_length_q;
	logic [gtsig_pkg::DIM_W-1:0]  row_count_q;
	logic [gtsig_pkg::STEP_W-1:0] step_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= gtsig_pkg::ROW_LENGTH_RST;
			row_count_q  <= gtsig_pkg::ROW_COUNT_RST;
			step_q       <= gtsig_pkg::STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gtsig_pkg::CFG_ROW_LENGTH: row_length_q <= cfg_wdata;
				gtsig_pkg::CFG_ROW_COUNT:  row_count_q  <= cfg_wdata;
				gtsig_pkg::CFG_STEP:       step_q       <= cfg_wdata[gtsig_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp dimensions to 2..max and treat a zero step as one
	always_comb begin
		if (row_length_q < gtsig_pkg::DIM_W'(2))
			cfg.row_length = gtsig_pkg::DIM_W'(2);
		else if (row_length_q > gtsig_pkg::DIM_W'(gtsig_pkg::MAX_GRID_DIM))
			cfg.row_length = gtsig_pkg::DIM_W'(gtsig_pkg::MAX_GRID_DIM);
		else
			cfg.row_length = row_length_q;

		if (row_count_q < gtsig_pkg::DIM_W'(2))
			cfg.row_count = gtsig_pkg::DIM_W'(2);
		else if (row_count_q > gtsig_pkg::DIM_W'(gtsig_pkg::MAX_GRID_DIM))
			cfg.row_count = gtsig_pkg::DIM_W'(gtsig_pkg::MAX_GRID_DIM);
		else
			cfg.row_count = row_count_q;

		cfg.step = (step_q == '0) ? gtsig_pkg::STEP_W'(1) : step_q;
	end

endmodule
`default_nettype wire

>>> design/gtsig_walk.sv
// strip walker: list state, next-index selection and the first pipeline stage
`default_nettype none
module gtsig_walk (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gtsig_pkg::cfg_t  cfg,
	gtsig_req_if.sink             req,
	input  wire logic             adv,
	output logic                  vld_s1,
	output gtsig_pkg::walk_t      walk_s1
);

	logic [gtsig_pkg::ROW_W-1:0] row_q;
	logic [gtsig_pkg::DIM_W-1:0] col_q;
	gtsig_pkg::phase_t           phase_q;
	logic [gtsig_pkg::POS_W-1:0] cnt_q;
	logic                        fin_q;

	// state as seen after a possible restart
	logic [gtsig_pkg::ROW_W-1:0] row_c;
	logic [gtsig_pkg::DIM_W-1:0] col_c;
	gtsig_pkg::phase_t           phase_c;
	logic [gtsig_pkg::POS_W-1:0] cnt_c;
	logic                        fin_c;

	// next state
	logic [gtsig_pkg::ROW_W-1:0] row_n;
	logic [gtsig_pkg::DIM_W-1:0] col_n;
	gtsig_pkg::phase_t           phase_n;
	logic [gtsig_pkg::POS_W-1:0] cnt_n;
	logic                        fin_n;

	logic [gtsig_pkg::ROW_W:0]   bot_row;
	logic [gtsig_pkg::DIM_W:0]   col_adv;
	logic [gtsig_pkg::ROW_W+1:0] row_adv2;
	gtsig_pkg::walk_t            walk_c;
	logic                        s1_en;
	logic                        accept;

	assign s1_en     = !vld_s1 || adv;
	assign req.ready = s1_en;
	assign accept    = req.valid && s1_en;

	// restart handling
	always_comb begin
		if (req.restart) begin
			row_c   = '0;
			col_c   = '0;
			phase_c = gtsig_pkg::PH_TOP;
			cnt_c   = '0;
			fin_c   = ({1'b0, cfg.step} >= cfg.row_count);
		end else begin
			row_c   = row_q;
			col_c   = col_q;
			phase_c = phase_q;
			cnt_c   = cnt_q;
			fin_c   = fin_q;
		end
	end

	// lower row, column advance and room for another strip
	assign bot_row  = {1'b0, row_c} + {2'b0, cfg.step};
	assign col_adv  = {1'b0, col_c} + {2'b0, cfg.step};
	assign row_adv2 = {1'b0, bot_row} + {3'b0, cfg.step};

	// pick the emitted vertex and advance the walk
	always_comb begin
		row_n   = row_c;
		col_n   = col_c;
		phase_n = phase_c;
		cnt_n   = cnt_c;
		fin_n   = fin_c;
		walk_c  = '0;
		if (!fin_c) begin
			walk_c.valid_res = 1'b1;
			walk_c.position  = cnt_c;
			cnt_n            = cnt_c + gtsig_pkg::POS_W'(1);
			case (phase_c)
				gtsig_pkg::PH_TOP: begin
					walk_c.row = {1'b0, row_c};
					walk_c.col = col_c;
					phase_n    = gtsig_pkg::PH_BOTTOM;
				end
				gtsig_pkg::PH_BOTTOM: begin
					walk_c.row = bot_row;
					walk_c.col = col_c;
					if (col_adv < {1'b0, cfg.row_length}) begin
						col_n   = col_adv[gtsig_pkg::DIM_W-1:0];
						phase_n = gtsig_pkg::PH_TOP;
					end else if ((cfg.row_count > {1'b0, cfg.step}) &&
						(row_adv2 < {2'b0, cfg.row_count})) begin
						phase_n = gtsig_pkg::PH_TRAIL;
					end else begin
						fin_n = 1'b1;
					end
				end
				gtsig_pkg::PH_TRAIL: begin
					walk_c.row = bot_row;
					walk_c.col = cfg.row_length - gtsig_pkg::DIM_W'(1);
					row_n      = bot_row[gtsig_pkg::ROW_W-1:0];
					col_n      = '0;
					phase_n    = gtsig_pkg::PH_LEAD;
				end
				default: begin
					// leading degenerate: repeat the row start
					walk_c.row = {1'b0, row_c};
					walk_c.col = '0;
					phase_n    = gtsig_pkg::PH_TOP;
				end
			endcase
			walk_c.is_last = fin_n;
		end
	end

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			phase_q <= gtsig_pkg::PH_TOP;
			cnt_q   <= '0;
			fin_q   <= 1'b1;
		end else if (accept) begin
			row_q   <= row_n;
			col_q   <= col_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			fin_q   <= fin_n;
		end
	end

	// first stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s1_en)
			vld_s1 <= req.valid;
	end

	// first stage payload
	always_ff @(posedge clk) begin
		if (accept)
			walk_s1 <= walk_c;
	end

endmodule
`default_nettype wire

>>> design/gtsig_index.sv
// vertex number computation and result register
`default_nettype none
module gtsig_index (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gtsig_pkg::cfg_t   cfg,
	input  wire logic              vld_s1,
	input  wire gtsig_pkg::walk_t  walk_s1,
	output logic                   adv,
	gtsig_res_if.source            res
);

	logic                                 vld_s2;
	logic [2*gtsig_pkg::DIM_W-1:0]        vi_sum;

	assign adv = !vld_s2 || res.ready;

	// row * row_length + column
	assign vi_sum = (2*gtsig_pkg::DIM_W)'(walk_s1.row) *
		(2*gtsig_pkg::DIM_W)'(cfg.row_length) + {gtsig_pkg::DIM_W'(0), walk_s1.col};

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv)
			vld_s2 <= vld_s1;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res.valid_res    <= walk_s1.valid_res;
			res.vertex_index <= vi_sum[gtsig_pkg::VI_W-1:0];
			res.position     <= walk_s1.position;
			res.is_last      <= walk_s1.is_last;
		end
	end

	assign res.valid = vld_s2;

endmodule
`default_nettype wire

>>> design/grid_triangle_strip_index_gen.sv
// Grid triangle strip index generator. Each request (restart or advance) yields one result:
// the next vertex index of a row-major grid walked as one stitched triangle strip, with its
// list position and a last mark, or an all-zero result with valid_res low once the list is
// finished or empty. One request is taken every clock cycle; a result passes through the strip
// walker register and then the result register, where the row times row_length multiply
// sits. Only a stalled result channel holds back requests. Configuration writes take effect at
// once and are meant to happen with no request in flight.
`default_nettype none
module grid_triangle_strip_index_gen (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [gtsig_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gtsig_pkg::CFG_DATA_W-1:0] cfg_wdata,
	gtsig_req_if.sink                             req,
	gtsig_res_if.source                           res
);

	gtsig_pkg::cfg_t  cfg;
	gtsig_pkg::walk_t walk_s1;
	logic             vld_s1;
	logic             adv;

	// configuration registers
	gtsig_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// strip walker
	gtsig_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.req     (req),
		.adv     (adv),
		.vld_s1  (vld_s1),
		.walk_s1 (walk_s1)
	);

	// index computation and output register
	gtsig_index u_index (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.vld_s1  (vld_s1),
		.walk_s1 (walk_s1),
		.adv     (adv),
		.res     (res)
	);

endmodule
`default_nettype wire

>>> tb/grid_triangle_strip_index_gen_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the grid triangle strip index generator
module grid_triangle_strip_index_gen_tb;
	import gtsig_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 900;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned MAX_WALK      = 64;

	// one result as it leaves the block
	typedef struct packed {
		logic             valid_res;
		logic [VI_W-1:0]  vertex_index;
		logic [POS_W-1:0] position;
		logic             is_last;
	} strip_index_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	gtsig_req_if req_bus ();
	gtsig_res_if res_bus ();

	grid_triangle_strip_index_gen u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.res       (res_bus)
	);

	// register copies as the block holds them
	logic [DIM_W-1:0]  grid_row_length = ROW_LENGTH_RST;
	logic [DIM_W-1:0]  grid_row_count  = ROW_COUNT_RST;
	logic [STEP_W-1:0] grid_step       = STEP_RST;

	// strip walker state of the predictor
	int unsigned       walk_row   = 0;
	int unsigned       walk_col   = 0;
	phase_t            walk_phase = PH_TOP;
	logic [POS_W-1:0]  list_count = '0;
	bit                list_done  = 1'b1;

	strip_index_t expected_indexes[$];

	int unsigned err_count     = 0;
	int unsigned requests_sent = 0;
	int unsigned useful_items  = 0;
	int unsigned results_seen  = 0;
	int unsigned indexes_seen  = 0;
	int unsigned list_ends     = 0;
	int unsigned reg_writes    = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned stall_left    = 0;
	bit          gaps_on       = 1'b1;
	bit          stalls_on     = 1'b1;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROW_LENGTH;
		cfg_wdata = '0;
		req_bus.valid = 1'b0;
		req_bus.restart = 1'b0;
		res_bus.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// pause length: mostly none, sometimes short, rarely long
	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
		if (v < 2)
			return 2;
		if (v > MAX_GRID_DIM)
			return MAX_GRID_DIM;
		return 32'(v);
	endfunction

	// next index of the stitched strip for one request
	function automatic strip_index_t next_strip_index(logic restart_bit);
		int unsigned  rl;
		int unsigned  rc;
		int unsigned  st;
		int unsigned  vi;
		strip_index_t r;
		rl = clamp_dim(grid_row_length);
		rc = clamp_dim(grid_row_count);
		st = (grid_step == '0) ? 1 : grid_step;
		vi = 0;
		r = '0;
		if (restart_bit) begin
			walk_row = 0;
			walk_col = 0;
			walk_phase = PH_TOP;
			list_count = '0;
			list_done = (st >= rc);
		end
		if (list_done)
			return r;
		case (walk_phase)
			PH_TOP: begin
				vi = walk_row * rl + walk_col;
				walk_phase = PH_BOTTOM;
			end
			PH_BOTTOM: begin
				vi = (walk_row + st) * rl + walk_col;
				if (walk_col + st < rl) begin
					walk_col += st;
					walk_phase = PH_TOP;
				end else if (rc > st && walk_row + st < rc - st) begin
					walk_phase = PH_TRAIL;
				end else begin
					list_done = 1'b1;
				end
			end
			// lower row end repeated after the strip
			PH_TRAIL: begin
				vi = (walk_row + st) * rl + (rl - 1);
				walk_row += st;
				walk_col = 0;
				walk_phase = PH_LEAD;
			end
			// row start repeated before the next strip
			default: begin
				vi = walk_row * rl;
				walk_phase = PH_TOP;
			end
		endcase
		r.valid_res = 1'b1;
		r.vertex_index = vi[VI_W-1:0];
		r.position = list_count;
		r.is_last = list_done;
		list_count = list_count + 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		err_count++;
	endtask

	// send one request and record its expected result
	task automatic send_request(input logic restart_bit);
		int unsigned  gap;
		strip_index_t want;
		gap = gaps_on ? pick_pause() : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid = 1'b1;
		req_bus.restart = restart_bit;
		do @(posedge clk); while (!req_bus.ready);
		want = next_strip_index(restart_bit);
		expected_indexes.push_back(want);
		requests_sent++;
		if (restart_bit || want.valid_res)
			useful_items++;
	endtask

	// hold requests until every expected result is back
	task automatic wait_results_drained();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (expected_indexes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		req_bus.valid = 1'b0;
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		case (idx)
			CFG_ROW_LENGTH: grid_row_length = value;
			CFG_ROW_COUNT:  grid_row_count = value;
			CFG_STEP:       grid_step = value[STEP_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_grid(input int unsigned rl, input int unsigned rc, input int unsigned st);
		wait_results_drained();
		write_register(CFG_ROW_LENGTH, rl[CFG_DATA_W-1:0]);
		write_register(CFG_ROW_COUNT, rc[CFG_DATA_W-1:0]);
		write_register(CFG_STEP, st[CFG_DATA_W-1:0]);
	endtask

	// walk one list: restart, then the given number of advances
	task automatic run_list(input int unsigned advances);
		send_request(1'b1);
		repeat (advances) send_request(1'b0);
	endtask

	// result channel ready with random stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_bus.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			res_bus.ready <= 1'b1;
			stall_left <= stalls_on ? pick_pause() : 0;
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		strip_index_t got;
		strip_index_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got.valid_res = res_bus.valid_res;
			got.vertex_index = res_bus.vertex_index;
			got.position = res_bus.position;
			got.is_last = res_bus.is_last;
			results_seen++;
			if (got.valid_res === 1'b1)
				indexes_seen++;
			if (got.is_last === 1'b1)
				list_ends++;
			if (expected_indexes.size() == 0) begin
				report_mismatch($sformatf("result %0d with no request waiting", results_seen));
			end else begin
				want = expected_indexes.pop_front();
				if (got.valid_res !== want.valid_res)
					report_mismatch($sformatf("result %0d valid_res %0b, expected %0b",
						results_seen, got.valid_res, want.valid_res));
				if (got.vertex_index !== want.vertex_index)
					report_mismatch($sformatf("result %0d vertex_index %0d, expected %0d",
						results_seen, got.vertex_index, want.vertex_index));
				if (got.position !== want.position)
					report_mismatch($sformatf("result %0d position %0d, expected %0d",
						results_seen, got.position, want.position));
				if (got.is_last !== want.is_last)
					report_mismatch($sformatf("result %0d is_last %0b, expected %0b",
						results_seen, got.is_last, want.is_last));
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_indexes.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// idle after reset, then a list on the reset grid
	task automatic test_reset_state();
		send_request(1'b0);
		send_request(1'b0);
		run_list(3);
	endtask

	// narrower rows take effect in the middle of a list
	task automatic test_change_mid_list();
		wait_results_drained();
		write_register(CFG_ROW_LENGTH, 11'd3);
		repeat (4) send_request(1'b0);
	endtask

	// 2 x 2 grid: one strip, then idle past the end
	task automatic test_smallest_grid();
		set_grid(2, 2, 1);
		run_list(4);
	endtask

	// two strips joined by trailing and leading repeats
	task automatic test_stitching();
		set_grid(3, 5, 2);
		run_list(9);
	endtask

	// largest grid, clamped registers, empty list
	task automatic test_extremes();
		set_grid(1024, 1024, 512);
		run_list(3);
		set_grid(0, 2047, 11'h400);
		run_list(2);
		set_grid(1, 1, 11'h3ff);
		run_list(1);
	endtask

	// random grids, mostly whole lists, some broken by restarts or register changes
	task automatic test_random_lists();
		int unsigned     target;
		int unsigned     mode;
		int unsigned     rl;
		int unsigned     rc;
		int unsigned     st;
		int unsigned     walked;
		int unsigned     extra;
		int unsigned     r;
		logic [CFG_IDX_W-1:0] sel;
		target = useful_items + RANDOM_ITEMS;
		while (useful_items < target) begin
			mode = $urandom_range(0, 9);
			case (mode)
				0: begin
					rl = $urandom_range(0, 2047);
					rc = $urandom_range(0, 2047);
					st = $urandom_range(0, 2047);
				end
				1: begin
					rl = $urandom_range(512, 1024);
					rc = $urandom_range(512, 1024);
					st = $urandom_range(rc / 3, 512);
				end
				2: begin
					rl = $urandom_range(2, 9);
					rc = $urandom_range(2, 9);
					st = $urandom_range(rc, rc + 20);
				end
				default: begin
					rl = $urandom_range(2, 9);
					rc = $urandom_range(2, 9);
					st = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, rc - 1);
				end
			endcase
			set_grid(rl, rc, st);
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 3)) begin
				send_request(1'b1);
				walked = 0;
				extra = $urandom_range(0, 3);
				while (walked < MAX_WALK && (!list_done || extra > 0)) begin
					if (list_done)
						extra--;
					r = $urandom_range(0, 99);
					if (r < 4) begin
						send_request(1'b1);
					end else if (r < 7 && !list_done) begin
						case ($urandom_range(0, 2))
							0: sel = CFG_ROW_LENGTH;
							1: sel = CFG_ROW_COUNT;
							default: sel = CFG_STEP;
						endcase
						wait_results_drained();
						write_register(sel, ($urandom_range(0, 1) != 0) ?
							CFG_DATA_W'($urandom_range(0, 2047)) :
							CFG_DATA_W'($urandom_range(0, 12)));
					end else begin
						send_request(1'b0);
					end
					walked++;
				end
			end
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	initial begin
		@(posedge arst_n);
		test_reset_state();
		test_change_mid_list();
		test_smallest_grid();
		test_stitching();
		test_extremes();
		test_random_lists();
		wait_results_drained();
		if (expected_indexes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_indexes.size()));
		$display("covered %0d requests and %0d results: %0d strip indexes, %0d list ends",
			requests_sent, results_seen, indexes_seen, list_ends);
		$display("%0d register writes across clamped, empty and mid-list grid settings",
			reg_writes);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
